### rtl/core/pfat_pkg.sv
package pfat_pkg;

    // field and register widths
    localparam int CFG_W    = 8;
    localparam int PID_W    = 6;
    localparam int PAGE_W   = 6;
    localparam int FRAME_W  = 7;
    localparam int NEED_W   = 7;
    localparam int STATUS_W = 3;

    localparam int FRAMES_DEF = 128;
    localparam int PROCS_DEF  = 64;
    localparam int PAGES_DEF  = 64;

    localparam logic [CFG_W-1:0] NUM_FRAMES_RST = 8'd128;

    localparam logic [STATUS_W-1:0] ST_ASSIGNED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_USED         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED     = 3'd4;

    // microcode addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_CLR       = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RC_INIT   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_RC        = 4'd2;
    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DEC       = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ASG       = 4'd5;
    localparam logic [STEP_W-1:0] STEP_REL_START = 4'd6;
    localparam logic [STEP_W-1:0] STEP_REL       = 4'd7;
    localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd8;

    typedef enum logic [2:0] {
        DP_NONE      = 3'd0,
        DP_CLEAR     = 3'd1,
        DP_RC_INIT   = 3'd2,
        DP_RECOUNT   = 3'd3,
        DP_ASSIGN    = 3'd4,
        DP_REL_START = 3'd5,
        DP_RELEASE   = 3'd6
    } dp_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD  = 2'd0,
        CNT_CLEAR = 2'd1,
        CNT_INC   = 2'd2
    } cnt_op_t;

    typedef enum logic {
        RD_ITEM = 1'b0,
        RD_WALK = 1'b1
    } rd_sel_t;

    typedef enum logic [2:0] {
        SEQ_NEXT   = 3'd0,
        SEQ_GOTO   = 3'd1,
        SEQ_BRANCH = 3'd2,  // cond ? target : step+1
        SEQ_WAIT   = 3'd3,  // cond ? step : target
        SEQ_DISP   = 3'd4   // idle dispatch: cfg -> target, item -> step+1
    } seq_op_t;

    typedef enum logic [2:0] {
        C_NONE     = 3'd0,
        C_CLR_MORE = 3'd1,
        C_RC_MORE  = 3'd2,
        C_REL_MORE = 3'd3,
        C_PID_BAD  = 3'd4,
        C_OUT_BUSY = 3'd5,
        C_IS_REL   = 3'd6
    } cond_sel_t;

    typedef struct packed {
        dp_op_t            op;
        cnt_op_t           cnt;
        rd_sel_t           rd;
        logic              cfg_en;
        logic              in_en;
        logic              emit;
        seq_op_t           seq;
        cond_sel_t         cond;
        logic [STEP_W-1:0] target;
    } pfat_ctrl_t;

    typedef struct packed {
        logic clr_more;
        logic rc_more;
        logic rel_more;
        logic pid_bad;
        logic out_busy;
        logic is_rel;
        logic cfg_hit;
        logic in_hit;
    } pfat_cond_t;

    function automatic pfat_ctrl_t ucode(input logic [STEP_W-1:0] step);
        pfat_ctrl_t c;
        c = '0;
        case (step)
            STEP_CLR:
            begin
                c.op     = DP_CLEAR;
                c.cnt    = CNT_INC;
                c.cfg_en = 1'b1;
                c.seq    = SEQ_WAIT;
                c.cond   = C_CLR_MORE;
                c.target = STEP_RC_INIT;
            end
            STEP_RC_INIT:
            begin
                c.op  = DP_RC_INIT;
                c.cnt = CNT_CLEAR;
                c.seq = SEQ_NEXT;
            end
            STEP_RC:
            begin
                c.op     = DP_RECOUNT;
                c.cnt    = CNT_INC;
                c.seq    = SEQ_WAIT;
                c.cond   = C_RC_MORE;
                c.target = STEP_IDLE;
            end
            STEP_IDLE:
            begin
                c.cnt    = CNT_CLEAR;
                c.cfg_en = 1'b1;
                c.in_en  = 1'b1;
                c.seq    = SEQ_DISP;
                c.target = STEP_RC_INIT;
            end
            STEP_DEC:
            begin
                c.rd     = RD_ITEM;
                c.seq    = SEQ_BRANCH;
                c.cond   = C_IS_REL;
                c.target = STEP_REL_START;
            end
            STEP_ASG:
            begin
                c.op     = DP_ASSIGN;
                c.seq    = SEQ_GOTO;
                c.target = STEP_EMIT;
            end
            STEP_REL_START:
            begin
                c.op     = DP_REL_START;
                c.rd     = RD_WALK;
                c.cnt    = CNT_INC;
                c.seq    = SEQ_BRANCH;
                c.cond   = C_PID_BAD;
                c.target = STEP_EMIT;
            end
            STEP_REL:
            begin
                c.op     = DP_RELEASE;
                c.rd     = RD_WALK;
                c.cnt    = CNT_INC;
                c.seq    = SEQ_WAIT;
                c.cond   = C_REL_MORE;
                c.target = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                c.emit   = 1'b1;
                c.seq    = SEQ_WAIT;
                c.cond   = C_OUT_BUSY;
                c.target = STEP_IDLE;
            end
            default:
            begin
                c.seq    = SEQ_GOTO;
                c.target = STEP_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

### rtl/core/page_frame_allocation_table.sv
// Assign: item accepted in idle, then the decode (table read), assign and emit steps; result registered at emit.
// Release: walks the process's PAGES page table entries one per cycle through the
// table memory port.
// A num_frames write recounts free frames before the next item is taken.
// Reset: page table cleared one entry per cycle, then free frames recounted; items are
// held off meanwhile, num_frames writes taken during the clear.
module page_frame_allocation_table #(
    parameter int FRAMES = pfat_pkg::FRAMES_DEF,
    parameter int PROCS  = pfat_pkg::PROCS_DEF,
    parameter int PAGES  = pfat_pkg::PAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pfat_pkg::CFG_W-1:0]     num_frames,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           req_type,
    input  logic [pfat_pkg::PID_W-1:0]     process_id,
    input  logic [pfat_pkg::PAGE_W-1:0]    page_index,
    input  logic [pfat_pkg::FRAME_W-1:0]   frame_number,
    input  logic [pfat_pkg::NEED_W-1:0]    process_pages,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pfat_pkg::STATUS_W-1:0]  status,
    output logic [pfat_pkg::CFG_W-1:0]     free_frames,
    output logic                           short_of_frames
);
    import pfat_pkg::*;

    localparam int DEPTH   = PROCS * PAGES;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW      = $clog2(FRAMES);
    localparam int MAX_A   = (DEPTH - 1 > FRAMES - 1) ? DEPTH - 1 : FRAMES - 1;
    localparam int CNT_MAX = (MAX_A > PAGES) ? MAX_A : PAGES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    pfat_ctrl_t ctrl;
    pfat_cond_t cond;

    // configuration and item registers
    logic [CFG_W-1:0]    num_frames_reg;
    logic                req_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [PAGE_W-1:0]   pg_reg;
    logic [FRAME_W-1:0]  fr_reg;
    logic [NEED_W-1:0]   need_reg;

    // datapath state
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [FRAMES-1:0]   fiu_reg;
    logic [FRAMES-1:0]   fiu_next;
    logic [CFG_W-1:0]    fc_reg;
    logic [CFG_W-1:0]    fc_next;
    logic [STATUS_W-1:0] st_reg;
    logic [STATUS_W-1:0] st_next;

    // page table memory: {valid, frame}
    logic [FW:0]         pt_mem [DEPTH];
    logic [FW:0]         rdata_reg;
    logic [AW-1:0]       rd_addr_reg;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       item_addr;
    logic [AW-1:0]       walk_addr;
    logic                we;
    logic [AW-1:0]       wa;
    logic [FW:0]         wd;

    // output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CFG_W-1:0]    free_reg;
    logic                short_reg;

    logic [CFG_W-1:0]    nf;
    logic                pid_bad;
    logic                pg_bad;
    logic [FW-1:0]       fr_idx;
    logic [FW-1:0]       old_fr;
    logic                old_valid;
    logic                old_counted;
    logic [STATUS_W-1:0] asg_status;
    logic                cfg_hit;
    logic                in_hit;
    logic                emit_go;

    pfat_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    assign cfg_ready = ctrl.cfg_en;
    assign in_stall  = !(ctrl.in_en && !cfg_valid);
    assign cfg_hit   = cfg_valid && cfg_ready;
    assign in_hit    = in_valid && !in_stall;

    assign nf = (int'(num_frames_reg) > FRAMES) ? CFG_W'(FRAMES) : num_frames_reg;

    assign pid_bad   = int'(pid_reg) >= PROCS;
    assign pg_bad    = int'(pg_reg) >= PAGES;
    assign item_addr = AW'(int'(pid_reg) * PAGES + int'(pg_reg));
    assign walk_addr = AW'(int'(pid_reg) * PAGES + int'(cnt_reg));
    assign rd_addr   = (ctrl.rd == RD_WALK) ? walk_addr : item_addr;

    assign fr_idx      = FW'(fr_reg);
    assign old_valid   = rdata_reg[FW];
    assign old_fr      = rdata_reg[FW-1:0];
    assign old_counted = old_valid && fiu_reg[old_fr] && (int'(old_fr) < int'(nf));

    always_comb
    begin
        if (({1'b0, need_reg} > nf) || pid_bad || pg_bad)
            asg_status = ST_TOO_LARGE;
        else if ({1'b0, fr_reg} >= nf)
            asg_status = ST_OUT_OF_RANGE;
        else if (fiu_reg[fr_idx])
            asg_status = ST_USED;
        else
            asg_status = ST_ASSIGNED;
    end

    always_comb
    begin
        cond.clr_more = int'(cnt_reg) != DEPTH - 1;
        cond.rc_more  = int'(cnt_reg) != FRAMES - 1;
        cond.rel_more = int'(cnt_reg) != PAGES;
        cond.pid_bad  = pid_bad;
        cond.out_busy = out_valid_reg && out_stall;
        cond.is_rel   = req_reg;
        cond.cfg_hit  = cfg_hit;
        cond.in_hit   = in_hit;
    end

    always_comb
    begin
        case (ctrl.cnt)
            CNT_CLEAR: cnt_next = '0;
            CNT_INC:   cnt_next = cnt_reg + CNT_W'(1);
            default:   cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        fiu_next = fiu_reg;
        fc_next  = fc_reg;
        st_next  = st_reg;
        we       = 1'b0;
        wa       = rd_addr_reg;
        wd       = '0;
        case (ctrl.op)
            DP_CLEAR:
            begin
                we = 1'b1;
                wa = cnt_reg[AW-1:0];
            end
            DP_RC_INIT:
                fc_next = '0;
            DP_RECOUNT:
            begin
                if (int'(cnt_reg) < int'(nf) && !fiu_reg[cnt_reg[FW-1:0]])
                    fc_next = fc_reg + CFG_W'(1);
            end
            DP_ASSIGN:
            begin
                st_next = asg_status;
                if (asg_status == ST_ASSIGNED)
                begin
                    we = 1'b1;
                    wa = item_addr;
                    wd = {1'b1, fr_idx};
                    // remap: the old frame is freed first, never the same as fr
                    if (old_valid)
                        fiu_next[old_fr] = 1'b0;
                    fiu_next[fr_idx] = 1'b1;
                    if (!old_counted)
                        fc_next = fc_reg - CFG_W'(1);
                end
            end
            DP_REL_START:
                st_next = ST_RELEASED;
            DP_RELEASE:
            begin
                if (old_valid)
                begin
                    we = 1'b1;
                    fiu_next[old_fr] = 1'b0;
                    if (old_counted)
                        fc_next = fc_reg + CFG_W'(1);
                end
            end
            default:
                st_next = st_reg;
        endcase
    end

    assign emit_go = ctrl.emit && !(out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (we)
            pt_mem[wa] <= wd;
        rdata_reg   <= pt_mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (in_hit)
        begin
            req_reg  <= req_type;
            pid_reg  <= process_id;
            pg_reg   <= page_index;
            fr_reg   <= frame_number;
            need_reg <= process_pages;
        end
        if (emit_go)
        begin
            status_reg <= st_reg;
            free_reg   <= fc_reg;
            short_reg  <= (fc_reg == '0) || (fc_reg < {1'b0, need_reg});
        end
        st_reg <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_frames_reg <= NUM_FRAMES_RST;
            cnt_reg        <= '0;
            fiu_reg        <= '0;
            fc_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
                num_frames_reg <= num_frames;
            cnt_reg <= cnt_next;
            fiu_reg <= fiu_next;
            fc_reg  <= fc_next;
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign free_frames     = free_reg;
    assign short_of_frames = short_reg;

endmodule

### rtl/core/pfat_seq.sv
module pfat_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfat_pkg::pfat_cond_t   cond,
    output pfat_pkg::pfat_ctrl_t   ctrl
);
    import pfat_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              cond_hit;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_CLR_MORE: cond_hit = cond.clr_more;
            C_RC_MORE:  cond_hit = cond.rc_more;
            C_REL_MORE: cond_hit = cond.rel_more;
            C_PID_BAD:  cond_hit = cond.pid_bad;
            C_OUT_BUSY: cond_hit = cond.out_busy;
            C_IS_REL:   cond_hit = cond.is_rel;
            default:    cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctrl.seq)
            SEQ_NEXT:   step_next = step_reg + STEP_W'(1);
            SEQ_GOTO:   step_next = ctrl.target;
            SEQ_BRANCH: step_next = cond_hit ? ctrl.target : step_reg + STEP_W'(1);
            SEQ_WAIT:   step_next = cond_hit ? step_reg : ctrl.target;
            SEQ_DISP:
            begin
                if (cond.cfg_hit)
                    step_next = ctrl.target;
                else if (cond.in_hit)
                    step_next = step_reg + STEP_W'(1);
                else
                    step_next = step_reg;
            end
            default:    step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_CLR;
        else
            step_reg <= step_next;
    end

endmodule

### verif/tb_page_frame_allocation_table.sv
module tb_page_frame_allocation_table;
    timeunit 1ns;
    timeprecision 1ps;

    import pfat_pkg::*;

    localparam int FRAMES = FRAMES_DEF;
    localparam int PROCS  = PROCS_DEF;
    localparam int PAGES  = PAGES_DEF;
    localparam int SLOT_W = PID_W + PAGE_W;

    localparam bit REQ_ASSIGN  = 1'b0;
    localparam bit REQ_RELEASE = 1'b1;

    typedef struct {
        bit                rel;
        bit [PID_W-1:0]    pid;
        bit [PAGE_W-1:0]   page;
        bit [FRAME_W-1:0]  frame;
        bit [NEED_W-1:0]   need;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [CFG_W-1:0]    free;
        logic                short_flag;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     num_frames;
    logic                 in_valid;
    logic                 in_stall;
    logic                 req_type;
    logic [PID_W-1:0]     process_id;
    logic [PAGE_W-1:0]    page_index;
    logic [FRAME_W-1:0]   frame_number;
    logic [NEED_W-1:0]    process_pages;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  status;
    logic [CFG_W-1:0]     free_frames;
    logic                 short_of_frames;

    // shadow of the allocator state
    bit [CFG_W-1:0]   frames_cfg;
    bit               frame_used [FRAMES];
    bit               map_valid [PROCS*PAGES];
    bit [FRAME_W-1:0] map_frame [PROCS*PAGES];
    int               free_cnt;

    outcome_t pending_outcomes [$];
    int       errors = 0;
    bit       calm = 1'b0;
    int       stall_left = 0;

    page_frame_allocation_table #(
        .FRAMES (FRAMES),
        .PROCS  (PROCS),
        .PAGES  (PAGES)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .num_frames      (num_frames),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .process_id      (process_id),
        .page_index      (page_index),
        .frame_number    (frame_number),
        .process_pages   (process_pages),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .free_frames     (free_frames),
        .short_of_frames (short_of_frames)
    );

    always #1 clk = ~clk;

    function automatic int usable_frames();
        return (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
    endfunction

    function automatic void recount_free();
        int nf;
        nf = usable_frames();
        free_cnt = 0;
        for (int i = 0; i < nf; i++)
            if (!frame_used[FRAME_W'(i)])
                free_cnt++;
    endfunction

    // frames at or above the usable count are never part of free_cnt
    function automatic void drop_frame(bit [FRAME_W-1:0] f);
        if (frame_used[f])
        begin
            frame_used[f] = 1'b0;
            if (int'(f) < usable_frames())
                free_cnt++;
        end
    endfunction

    function automatic outcome_t allocate_or_release(request_t r);
        outcome_t        o;
        int              nf;
        bit [SLOT_W-1:0] slot;
        nf = usable_frames();
        if (r.rel == REQ_RELEASE)
        begin
            if (int'(r.pid) < PROCS)
            begin
                for (int p = 0; p < PAGES; p++)
                begin
                    slot = SLOT_W'(int'(r.pid) * PAGES + p);
                    if (map_valid[slot])
                    begin
                        drop_frame(map_frame[slot]);
                        map_valid[slot] = 1'b0;
                        map_frame[slot] = '0;
                    end
                end
            end
            o.status = ST_RELEASED;
        end
        else if (int'(r.need) > nf || int'(r.pid) >= PROCS || int'(r.page) >= PAGES)
            o.status = ST_TOO_LARGE;
        else if (int'(r.frame) >= nf)
            o.status = ST_OUT_OF_RANGE;
        else if (frame_used[r.frame])
            o.status = ST_USED;
        else
        begin
            slot = SLOT_W'(int'(r.pid) * PAGES + int'(r.page));
            // remap: give back the old frame first
            if (map_valid[slot])
                drop_frame(map_frame[slot]);
            frame_used[r.frame] = 1'b1;
            free_cnt--;
            map_valid[slot] = 1'b1;
            map_frame[slot] = r.frame;
            o.status = ST_ASSIGNED;
        end
        o.free = free_cnt[CFG_W-1:0];
        o.short_flag = (free_cnt == 0 || free_cnt < int'(r.need));
        return o;
    endfunction

    task automatic flag_error(string msg);
        if (errors < 50)
            $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic send_request(request_t r);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= r.rel;
        process_id    <= r.pid;
        page_index    <= r.page;
        frame_number  <= r.frame;
        process_pages <= r.need;
        do
            @(posedge clk);
        while (in_stall);
        pending_outcomes.push_back(allocate_or_release(r));
    endtask

    task automatic assign_page(int pid, int page, int frame, int need);
        request_t r;
        r.rel   = REQ_ASSIGN;
        r.pid   = PID_W'(pid);
        r.page  = PAGE_W'(page);
        r.frame = FRAME_W'(frame);
        r.need  = NEED_W'(need);
        send_request(r);
    endtask

    task automatic release_process(int pid, int need);
        request_t r;
        r.rel   = REQ_RELEASE;
        r.pid   = PID_W'(pid);
        r.page  = PAGE_W'($urandom_range(0, PAGES - 1));
        r.frame = FRAME_W'($urandom_range(0, FRAMES - 1));
        r.need  = NEED_W'(need);
        send_request(r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_frame_count(bit [CFG_W-1:0] value);
        wait_drained();
        cfg_valid  <= 1'b1;
        num_frames <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        frames_cfg = value;
        recount_free();
    endtask

    function automatic request_t random_request(int nf);
        request_t r;
        int       pick;
        int       cap;
        pick = $urandom_range(0, 99);
        cap  = (nf < 64) ? nf : 64;
        r.rel   = ($urandom_range(0, 99) < 12) ? REQ_RELEASE : REQ_ASSIGN;
        // a few busy processes so releases free real mappings
        r.pid   = PID_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, PROCS - 1)
                                                     : $urandom_range(0, 7));
        r.page  = PAGE_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                               : $urandom_range(0, PAGES - 1));
        r.frame = FRAME_W'((nf > 0 && pick < 85) ? $urandom_range(0, nf - 1)
                                                 : $urandom_range(0, (1 << FRAME_W) - 1));
        r.need  = NEED_W'((pick < 80) ? $urandom_range(0, cap)
                                      : $urandom_range(0, (1 << NEED_W) - 1));
        return r;
    endfunction

    task automatic test_assign_and_remap();
        assign_page(0, 0, 0, 0);
        assign_page(1, 0, 0, 0);        // frame taken
        assign_page(63, 63, 127, 64);
        assign_page(0, 0, 5, 3);        // remap frees frame 0
        assign_page(2, 1, 6, 127);      // short of frames
        release_process(0, 0);
        release_process(0, 1);          // nothing left to free
        release_process(63, 0);
    endtask

    task automatic test_frame_limits();
        set_frame_count(8'd1);
        assign_page(3, 0, 0, 1);
        assign_page(3, 1, 1, 0);        // out of range
        assign_page(3, 2, 0, 2);        // too large wins over the used check
        assign_page(4, 0, 0, 0);        // used
        release_process(2, 0);          // frame 6 sits above the limit
        set_frame_count(8'd0);
        assign_page(4, 0, 0, 0);
        assign_page(4, 0, 0, 1);
        release_process(3, 0);
        set_frame_count(8'd128);
        assign_page(5, 0, 100, 10);
        set_frame_count(8'd16);
        assign_page(5, 0, 3, 16);       // old frame not counted back
        release_process(5, 17);
        set_frame_count(8'd255);        // saturates at FRAMES
        assign_page(6, 9, 127, 127);
        release_process(6, 0);
    endtask

    task automatic test_random_traffic();
        bit [CFG_W-1:0] settings [7] = '{8'd255, 8'd37, 8'd1, 8'd6, 8'd0, 8'd200, 8'd128};
        for (bit [2:0] ph = 3'd0; ph < 3'd7; ph++)
        begin
            set_frame_count(settings[ph]);
            calm = (ph == 3'd6);
            repeat (100)
                send_request(random_request(usable_frames()));
        end
    endtask

    // receiver stalls in random bursts unless calm
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left <= int'($urandom_range(0, 5));
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
                flag_error("result with no request pending");
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("status %0d, expected %0d", status, want.status));
                if (free_frames !== want.free)
                    flag_error($sformatf("free_frames %0d, expected %0d",
                                         free_frames, want.free));
                if (short_of_frames !== want.short_flag)
                    flag_error($sformatf("short_of_frames %0b, expected %0b",
                                         short_of_frames, want.short_flag));
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        num_frames    = NUM_FRAMES_RST;
        in_valid      = 1'b0;
        req_type      = REQ_ASSIGN;
        process_id    = '0;
        page_index    = '0;
        frame_number  = '0;
        process_pages = '0;
        out_stall     = 1'b0;
        frames_cfg    = NUM_FRAMES_RST;
        recount_free();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_assign_and_remap();
        test_frame_limits();
        test_random_traffic();

        in_valid <= 1'b0;
        for (int n = 0; n < 5000 && pending_outcomes.size() != 0; n++)
            @(posedge clk);
        repeat (PAGES + 8) @(posedge clk);
        if (pending_outcomes.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));
        if (errors == 0)
            $display("page_frame_allocation_table regression: pass");
        else
            $display("page_frame_allocation_table regression: fail");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("page_frame_allocation_table regression: fail");
        $finish;
    end

endmodule

### page_frame_allocation_table.f
rtl/core/pfat_pkg.sv
rtl/core/pfat_seq.sv
rtl/core/page_frame_allocation_table.sv
verif/tb_page_frame_allocation_table.sv
